// ===== sv/unique_key_table_top_assert.svh =====
// assertion macros for the unique key table
`ifndef UNIQUE_KEY_TABLE_TOP_ASSERT_SVH
`define UNIQUE_KEY_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define UKT_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("unique key table check failed");

// next-cycle implication
`define UKT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("unique key table check failed");

`endif

// ===== sv/ukt_pkg.sv =====
// types and codes shared by the unique key table files
package ukt_pkg;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_DEL = 2'd1,
		CMD_UPD = 2'd2,
		CMD_GET = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_ADD_DUP  = 3'd2,
		ST_GET_MISS = 3'd3,
		ST_DEL_MISS = 3'd4,
		ST_UPD_MISS = 3'd5,
		ST_UPD_DUP  = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} fsm_t;

	localparam int KEY_W    = 32;
	localparam int PAY_W    = 64;
	localparam int CNT_W    = 5;
	localparam int CAP_W    = 5;
	localparam int STATUS_W = 3;
	localparam int CMD_W    = 2;

endpackage

// ===== sv/ukt_if.sv =====
// command and response channels of the unique key table
interface ukt_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        cmd;
	logic signed [31:0] key;
	logic signed [31:0] new_key;
	logic [63:0]       payload;

	modport source (output valid, cmd, key, new_key, payload, input ready);
	modport sink (input valid, cmd, key, new_key, payload, output ready);
endinterface

interface ukt_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] read_payload;
	logic [4:0]  entry_count;

	modport source (output valid, status, read_payload, entry_count, input ready);
	modport sink (input valid, status, read_payload, entry_count, output ready);
endinterface

// ===== sv/unique_key_table_top.sv =====
// unique key table: packed key/payload table with add, delete, update and get
// One command at a time. A command reads the key and payload memories (one
// registered read port) once per held entry to find the key before its
// response is loaded; an add into a full table skips the scan. A delete
// then walks the later entries once more, moving each down one place
// through the same read port and the write port. The next command is taken
// once the response is in the output register, even if it has not been
// consumed yet. Capacity writes go straight to the register and values
// above DEPTH act as DEPTH.
`include "unique_key_table_top_assert.svh"

module unique_key_table_top #(
	parameter int DEPTH        = 16,
	parameter int PAYLOAD_BITS = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [ukt_pkg::CAP_W-1:0] cfg_wdata,
	ukt_req_if.sink                  req,
	ukt_rsp_if.source                rsp
);
	import ukt_pkg::*;

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	// storage
	logic [KEY_W-1:0]        key_mem [DEPTH];
	logic [PAYLOAD_BITS-1:0] pay_mem [DEPTH];

	// control registers
	fsm_t             state_q, state_d;
	logic [CAP_W-1:0] cap_q;
	logic [CW-1:0]    count_q;
	logic             cmp_v_s1;
	logic             rsp_valid_q;

	// working registers
	cmd_t                    op_q;
	logic [KEY_W-1:0]        key_q;
	logic [KEY_W-1:0]        nkey_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic [CW-1:0]           ptr_q;
	logic                    found_q;
	logic [AW-1:0]           hit_idx_q;
	logic                    nk_other_q;
	logic [PAYLOAD_BITS-1:0] get_pay_q;
	status_t                 res_q, res_d;
	logic [AW-1:0]           cmp_idx_s1;
	logic [KEY_W-1:0]        rd_key_s1;
	logic [PAYLOAD_BITS-1:0] rd_pay_s1;
	status_t                 rsp_status_q;
	logic [PAY_W-1:0]        rsp_pay_q;
	logic [CNT_W-1:0]        rsp_cnt_q;

	// memory port controls
	logic                    rd_en;
	logic [AW-1:0]           rd_addr;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic [KEY_W-1:0]        wr_key;
	logic [PAYLOAD_BITS-1:0] wr_pay;

	logic            accept;
	logic            full;
	logic            rd_more;
	logic            key_hit;
	logic            first_hit;
	logic            cnt_inc;
	logic            cnt_dec;
	logic            load_rsp;
	logic [CMPW-1:0] count_ext;

	assign count_ext = CMPW'(count_q);
	assign full      = (count_ext >= CMPW'(cap_q)) || (count_q == DEPTH_C);
	assign rd_more   = ptr_q < count_q;
	assign key_hit   = rd_key_s1 == key_q;
	assign first_hit = key_hit && !found_q;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.read_payload = rsp_pay_q;
	assign rsp.entry_count  = rsp_cnt_q;

	always_comb begin
		state_d  = state_q;
		res_d    = res_q;
		rd_en    = 1'b0;
		rd_addr  = ptr_q[AW-1:0];
		wr_en    = 1'b0;
		wr_addr  = hit_idx_q;
		wr_key   = nkey_q;
		wr_pay   = pay_q;
		cnt_inc  = 1'b0;
		cnt_dec  = 1'b0;
		load_rsp = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					if (cmd_t'(req.cmd) == CMD_ADD && full) begin
						res_d   = ST_FULL;
						state_d = S_DONE;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				rd_en = rd_more;
				if (!rd_more && !cmp_v_s1) begin
					state_d = S_DONE;
					res_d   = ST_OK;
					case (op_q)
						CMD_ADD: begin
							if (found_q) begin
								res_d = ST_ADD_DUP;
							end else begin
								wr_en   = 1'b1;
								wr_addr = count_q[AW-1:0];
								wr_key  = key_q;
								cnt_inc = 1'b1;
							end
						end
						CMD_DEL: begin
							if (!found_q) begin
								res_d = ST_DEL_MISS;
							end else begin
								state_d = S_SHIFT;
							end
						end
						CMD_UPD: begin
							if (!found_q) begin
								res_d = ST_UPD_MISS;
							end else if (nk_other_q) begin
								res_d = ST_UPD_DUP;
							end else begin
								wr_en = 1'b1;
							end
						end
						default: begin
							if (!found_q) begin
								res_d = ST_GET_MISS;
							end
						end
					endcase
				end
			end
			S_SHIFT: begin
				// read entry j+2 while writing entry j, never the same address
				rd_en = rd_more;
				if (cmp_v_s1) begin
					wr_en   = 1'b1;
					wr_addr = cmp_idx_s1 - AW'(1);
					wr_key  = rd_key_s1;
					wr_pay  = rd_pay_s1;
				end
				if (!rd_more && !cmp_v_s1) begin
					cnt_dec = 1'b1;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					load_rsp = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cap_q       <= CAP_W'(16);
			count_q     <= '0;
			cmp_v_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cmp_v_s1 <= rd_en;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q      <= res_d;
		cmp_idx_s1 <= rd_addr;
		if (accept) begin
			op_q       <= cmd_t'(req.cmd);
			key_q      <= req.key;
			nkey_q     <= req.new_key;
			pay_q      <= req.payload[PAYLOAD_BITS-1:0];
			ptr_q      <= '0;
			found_q    <= 1'b0;
			nk_other_q <= 1'b0;
		end
		if (rd_en) begin
			ptr_q <= ptr_q + CW'(1);
		end
		if (state_q == S_SCAN && state_d == S_SHIFT) begin
			ptr_q <= CW'(hit_idx_q) + CW'(1);
		end
		if (state_q == S_SCAN && cmp_v_s1) begin
			if (first_hit) begin
				found_q   <= 1'b1;
				hit_idx_q <= cmp_idx_s1;
				get_pay_q <= rd_pay_s1;
			end
			if (rd_key_s1 == nkey_q && !first_hit) begin
				nk_other_q <= 1'b1;
			end
		end
		if (load_rsp) begin
			rsp_status_q <= res_q;
			rsp_pay_q    <= (res_q == ST_OK && op_q == CMD_GET) ? PAY_W'(get_pay_q) : '0;
			rsp_cnt_q    <= count_ext[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			pay_mem[wr_addr] <= wr_pay;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key_s1 <= key_mem[rd_addr];
			rd_pay_s1 <= pay_mem[rd_addr];
		end
	end

	`UKT_ASSERT_NEXT(a_accept_starts, accept, state_q != S_IDLE)
	`UKT_ASSERT_IMPL(a_write_busy, wr_en, (state_q == S_SCAN) || (state_q == S_SHIFT))
	`UKT_ASSERT_IMPL(a_read_held, rd_en, CW'(rd_addr) < count_q)
	`UKT_ASSERT_NEXT(a_count_quiet, (state_q == S_IDLE) || (state_q == S_DONE), $stable(count_q))

endmodule
